### sv/idcs_pkg.sv
// shared types, codes and tables for the isa dma channel setup block
`default_nettype none

package idcs_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CHAN_IDX_W   = $clog2(NUM_CHANNELS);

    // commands
    localparam logic [1:0] CMD_PREPARE = 2'd0;
    localparam logic [1:0] CMD_START   = 2'd1;
    localparam logic [1:0] CMD_STOP    = 2'd2;
    localparam logic [1:0] CMD_STATUS  = 2'd3;

    // result codes
    localparam logic [2:0] RC_OK        = 3'd0;
    localparam logic [2:0] RC_INVALID   = 3'd1;
    localparam logic [2:0] RC_ADDR_HIGH = 3'd2;
    localparam logic [2:0] RC_BAD_LEN   = 3'd3;
    localparam logic [2:0] RC_CASCADE   = 3'd4;

    // channel status
    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_PREPARED = 2'd1;
    localparam logic [1:0] ST_RUNNING  = 2'd2;
    localparam logic [1:0] ST_ERROR    = 2'd3;

    localparam logic [CHAN_IDX_W-1:0] CASCADE_CHAN = CHAN_IDX_W'(4);

    localparam logic [31:0] LIMIT_LO_BYTES = 32'h0001_0000;
    localparam logic [31:0] LIMIT_HI_BYTES = 32'h0002_0000;
    localparam logic [31:0] ADDR_LIMIT     = 32'h00FF_FFFF;

    localparam logic [7:0] MODE_SINGLE = 8'h40;
    localparam logic [7:0] MODE_READ   = 8'h08;
    localparam logic [7:0] MODE_WRITE  = 8'h04;
    localparam logic [7:0] WIDE_BASE   = 8'hC0;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  chan;
        logic [31:0] buf_addr;
        logic [31:0] xfer_len;
        logic        to_device;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  result_code;
        logic [1:0]  chan_status;
        logic [17:0] remaining_bytes;
        logic [7:0]  mode_byte;
        logic [15:0] addr_word;
        logic [7:0]  addr_page;
        logic [15:0] count_word;
        logic [7:0]  reg_base;
        logic [7:0]  page_port;
        logic [2:0]  mask_byte;
        logic        regs_valid;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

    function automatic logic [7:0] page_port_of(input logic [CHAN_IDX_W-1:0] ch);
        logic [7:0] port;
        unique case (ch)
            3'd0:    port = 8'h87;
            3'd1:    port = 8'h83;
            3'd2:    port = 8'h81;
            3'd3:    port = 8'h82;
            3'd5:    port = 8'h8B;
            3'd6:    port = 8'h89;
            3'd7:    port = 8'h8A;
            default: port = 8'h00;
        endcase
        return port;
    endfunction

endpackage

`default_nettype wire

### sv/idcs_ctrl.sv
// controller: sequences capture and execute of one item
`default_nettype none

module idcs_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    output idcs_pkg::t_dp_cmd     o_cmd,
    output logic                  o_result_valid
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_EXEC);
        end
    end

    assign busy           = (r_state == S_EXEC);
    assign o_cmd.load     = (r_state == S_IDLE) && start;
    assign o_cmd.exec     = (r_state == S_EXEC);
    assign o_result_valid = r_valid;

endmodule

`default_nettype wire

### sv/idcs_dp.sv
// datapath: channel table, prepare checks and register value derivation
`default_nettype none

module idcs_dp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire idcs_pkg::t_dp_cmd    i_cmd,
    input  wire idcs_pkg::t_in_item   i_item,
    output idcs_pkg::t_out_item       o_result
);

    localparam int IW = idcs_pkg::CHAN_IDX_W;
    localparam int NC = idcs_pkg::NUM_CHANNELS;

    idcs_pkg::t_in_item  r_in;
    idcs_pkg::t_out_item r_res;
    idcs_pkg::t_out_item n_res;

    logic        r_used [NC];
    logic [1:0]  r_st   [NC];
    logic [17:0] r_len  [NC];

    logic [IW-1:0] idx;
    logic          wide;
    logic [1:0]    n_st;
    logic          prep_ok;
    logic [31:0]   limit;
    logic [15:0]   count_base;

    always_comb begin
        idx        = r_in.chan[IW-1:0];
        wide       = idx[IW-1];
        limit      = wide ? idcs_pkg::LIMIT_HI_BYTES : idcs_pkg::LIMIT_LO_BYTES;
        count_base = wide ? r_in.xfer_len[16:1] : r_in.xfer_len[15:0];
        n_st       = r_st[idx];
        prep_ok    = 1'b0;
        n_res      = '0;

        if (r_in.chan[3]) begin
            n_res.result_code = idcs_pkg::RC_INVALID;
        end else begin
            priority if (r_in.cmd == idcs_pkg::CMD_STATUS) begin
                n_res.remaining_bytes = r_used[idx] ? r_len[idx] : 18'd0;
            end else if (idx == idcs_pkg::CASCADE_CHAN) begin
                n_res.result_code = idcs_pkg::RC_CASCADE;
            end else begin
                unique case (r_in.cmd)
                    idcs_pkg::CMD_PREPARE: begin
                        priority if (r_in.buf_addr > idcs_pkg::ADDR_LIMIT) begin
                            n_res.result_code = idcs_pkg::RC_ADDR_HIGH;
                        end else if (r_in.xfer_len == 32'd0 || r_in.xfer_len > limit) begin
                            n_res.result_code = idcs_pkg::RC_BAD_LEN;
                        end else if (wide && r_in.buf_addr[0]) begin
                            n_res.result_code = idcs_pkg::RC_INVALID;
                        end else begin
                            prep_ok          = 1'b1;
                            n_st             = idcs_pkg::ST_PREPARED;
                            n_res.mode_byte  = idcs_pkg::MODE_SINGLE
                                | (r_in.to_device ? idcs_pkg::MODE_READ
                                                  : idcs_pkg::MODE_WRITE)
                                | {6'd0, idx[1:0]};
                            n_res.addr_word  = wide ? r_in.buf_addr[16:1]
                                                    : r_in.buf_addr[15:0];
                            n_res.addr_page  = r_in.buf_addr[23:16];
                            n_res.count_word = count_base - 16'd1;
                            n_res.reg_base   = (wide ? idcs_pkg::WIDE_BASE : 8'h00)
                                | {5'd0, idx[1:0], 1'b0};
                            n_res.page_port  = idcs_pkg::page_port_of(idx);
                            n_res.mask_byte  = {1'b1, idx[1:0]};
                            n_res.regs_valid = 1'b1;
                        end
                    end
                    idcs_pkg::CMD_START: begin
                        if (!r_used[idx] || !r_st[idx][0]) begin
                            n_res.result_code = idcs_pkg::RC_INVALID;
                        end else begin
                            n_st            = idcs_pkg::ST_RUNNING;
                            n_res.mask_byte = {1'b0, idx[1:0]};
                        end
                    end
                    idcs_pkg::CMD_STOP: begin
                        if (r_st[idx] == idcs_pkg::ST_RUNNING) begin
                            n_st = idcs_pkg::ST_PREPARED;
                        end
                        n_res.mask_byte = {1'b1, idx[1:0]};
                    end
                    default: begin
                        // status query is handled above
                    end
                endcase
            end
        end

        n_res.chan_status = r_in.chan[3] ? idcs_pkg::ST_ERROR : n_st;
    end

    // control state of the channel table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NC; i++) begin
                r_used[i] <= 1'b0;
                r_st[i]   <= idcs_pkg::ST_IDLE;
            end
        end else if (i_cmd.exec && !r_in.chan[3]) begin
            r_st[idx] <= n_st;
            if (prep_ok) r_used[idx] <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_item;
        if (i_cmd.exec) r_res <= n_res;
        if (i_cmd.exec && prep_ok) r_len[idx] <= r_in.xfer_len[17:0];
    end

    assign o_result = r_res;

endmodule

`default_nettype wire

### sv/isa_dma_channel_setup.sv
// top level: isa dma channel setup, controller plus datapath
//
//  channel   signals                        direction  transfer rule
//  command   start, busy, i_item            in         taken when start && !busy
//  result    o_result_valid, o_result       out        one cycle strobe, no stall
//
// items are taken one at a time: a capture edge, then the execute state, which
// reads and updates the eight-entry channel table through a single port.
// the result shows in the cycle after the execute cycle, on the same cycle in
// which busy is low again and the next item can be taken.
// synchronous active-low reset clears channel used and status bits.
// the receiver cannot stall; each result is qualified by the o_result_valid strobe.
`default_nettype none

module isa_dma_channel_setup (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire idcs_pkg::t_in_item   i_item,
    output logic                      o_result_valid,
    output idcs_pkg::t_out_item       o_result
);

    idcs_pkg::t_dp_cmd dp_cmd;

    idcs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .o_cmd          (dp_cmd),
        .o_result_valid (o_result_valid)
    );

    idcs_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
